FILE: sv/cmap_pkg.sv
// Package for the intensity-to-RGB colormap: widths, segment codes,
// beat types between pipeline stages and the per-segment ramp coefficient tables.
// No dependencies.
`timescale 1ns / 1ps

package cmap_pkg;

   // Fixed-point format of the intensity and derived widths
   localparam int FRAC_BITS = 16;
   localparam int IN_W      = 18;
   localparam int CH_W      = 8;
   localparam int XW        = FRAC_BITS + 1;                      // clamped x, 0..ONE
   localparam int CLW       = (FRAC_BITS + 1 > 17) ? FRAC_BITS + 1 : 17;
   localparam int CW        = FRAC_BITS + 5;                      // 20*x fits here
   localparam int UW        = FRAC_BITS + 2;                      // ramp offset, below 3*ONE
   localparam int MULT_W    = 9;
   localparam int PW        = FRAC_BITS + MULT_W;                 // product, below 512*ONE
   localparam int SEG_W     = 3;

   localparam longint unsigned ONE_L = 64'd1 << FRAC_BITS;

   // Segment codes, lowest intensity first
   localparam logic [SEG_W-1:0] SEG_DARK   = 3'd0;   // below 0.1
   localparam logic [SEG_W-1:0] SEG_BLUE   = 3'd1;   // 0.1 .. 0.3
   localparam logic [SEG_W-1:0] SEG_CYAN   = 3'd2;   // 0.3 .. 0.5
   localparam logic [SEG_W-1:0] SEG_GREEN  = 3'd3;   // 0.5 .. 0.7
   localparam logic [SEG_W-1:0] SEG_YELLOW = 3'd4;   // 0.7 .. 0.85
   localparam logic [SEG_W-1:0] SEG_ORANGE = 3'd5;   // 0.85 .. 0.95
   localparam logic [SEG_W-1:0] SEG_HOT    = 3'd6;   // 0.95 and above

   // Divisor applied to the product: ONE, 2*ONE or 3*ONE
   localparam logic [1:0] DIV_ONE   = 2'd0;
   localparam logic [1:0] DIV_TWO   = 2'd1;
   localparam logic [1:0] DIV_THREE = 2'd2;

   // One channel's ramp: base +/- (mult * u / divisor); a falling ramp rounds up
   typedef struct packed {
      logic [CH_W-1:0]   base;
      logic              neg;
      logic [MULT_W-1:0] mult;
      logic [1:0]        div;
   } coef_type;

   typedef struct packed {
      logic [XW-1:0] x;
   } x_beat_type;

   typedef struct packed {
      logic [SEG_W-1:0] seg;
      logic [UW-1:0]    u;
   } seg_beat_type;

   typedef struct packed {
      logic [SEG_W-1:0] seg;
      logic [PW-1:0]    p_red;
      logic [PW-1:0]    p_green;
      logic [PW-1:0]    p_blue;
   } prod_beat_type;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
   } rgb_beat_type;

   function automatic coef_type coef_red(input logic [SEG_W-1:0] seg);
      coef_type c;
      unique case (seg)
         SEG_DARK:   c = '{8'd0,   1'b0, 9'd0,  DIV_ONE};
         SEG_BLUE:   c = '{8'd0,   1'b0, 9'd0,  DIV_ONE};
         SEG_CYAN:   c = '{8'd0,   1'b0, 9'd40, DIV_ONE};
         SEG_GREEN:  c = '{8'd80,  1'b0, 9'd40, DIV_ONE};
         SEG_YELLOW: c = '{8'd160, 1'b0, 9'd95, DIV_THREE};
         SEG_ORANGE: c = '{8'd255, 1'b0, 9'd0,  DIV_ONE};
         SEG_HOT:    c = '{8'd255, 1'b0, 9'd0,  DIV_ONE};
         default:    c = '{8'd0,   1'b0, 9'd0,  DIV_ONE};
      endcase
      return c;
   endfunction

   function automatic coef_type coef_green(input logic [SEG_W-1:0] seg);
      coef_type c;
      unique case (seg)
         SEG_DARK:   c = '{8'd0,   1'b0, 9'd200, DIV_ONE};
         SEG_BLUE:   c = '{8'd20,  1'b0, 9'd30,  DIV_ONE};
         SEG_CYAN:   c = '{8'd80,  1'b0, 9'd40,  DIV_ONE};
         SEG_GREEN:  c = '{8'd160, 1'b0, 9'd95,  DIV_TWO};
         SEG_YELLOW: c = '{8'd255, 1'b0, 9'd0,   DIV_ONE};
         SEG_ORANGE: c = '{8'd255, 1'b1, 9'd64,  DIV_ONE};
         SEG_HOT:    c = '{8'd0,   1'b0, 9'd0,   DIV_ONE};
         default:    c = '{8'd0,   1'b0, 9'd0,   DIV_ONE};
      endcase
      return c;
   endfunction

   function automatic coef_type coef_blue(input logic [SEG_W-1:0] seg);
      coef_type c;
      unique case (seg)
         SEG_DARK:   c = '{8'd0,   1'b0, 9'd300, DIV_ONE};
         SEG_BLUE:   c = '{8'd30,  1'b0, 9'd75,  DIV_ONE};
         SEG_CYAN:   c = '{8'd180, 1'b0, 9'd75,  DIV_TWO};
         SEG_GREEN:  c = '{8'd255, 1'b1, 9'd100, DIV_ONE};
         SEG_YELLOW: c = '{8'd55,  1'b1, 9'd55,  DIV_THREE};
         SEG_ORANGE: c = '{8'd0,   1'b0, 9'd0,   DIV_ONE};
         SEG_HOT:    c = '{8'd0,   1'b0, 9'd100, DIV_ONE};
         default:    c = '{8'd0,   1'b0, 9'd0,   DIV_ONE};
      endcase
      return c;
   endfunction

endpackage

FILE: sv/cmap_clamp.sv
// First pipeline stage of the colormap: clamps the signed intensity to 0..ONE.
// Depends on cmap_pkg.
`timescale 1ns / 1ps

module cmap_clamp (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic signed [cmap_pkg::IN_W-1:0]    in_intensity,
   output logic                                out_valid,
   input  logic                                out_ready,
   output cmap_pkg::x_beat_type                out_beat
);
   import cmap_pkg::*;

   localparam logic [CLW-1:0] ONE_C = CLW'(ONE_L);

   logic             valid_ff;
   logic             valid_in;
   x_beat_type       beat_ff;
   x_beat_type       beat_in;
   logic [CLW-1:0]   pos_ext;
   logic [CLW-1:0]   x_sel;

   // Negative reads as zero, above one saturates at one
   always_comb begin
      pos_ext = CLW'(in_intensity[IN_W-2:0]);
      if (in_intensity[IN_W-1]) begin
         x_sel = '0;
      end else if (pos_ext > ONE_C) begin
         x_sel = ONE_C;
      end else begin
         x_sel = pos_ext;
      end
      beat_in.x = x_sel[XW-1:0];
   end

   // Advance when this stage is empty or its beat moves on
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         beat_ff <= beat_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_beat  = beat_ff;

endmodule

FILE: sv/cmap_segment.sv
// Second pipeline stage of the colormap: finds the segment by exact multiples
// of ONE and forms the ramp offset u. Depends on cmap_pkg.
`timescale 1ns / 1ps

module cmap_segment (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  cmap_pkg::x_beat_type   in_beat,
   output logic                   out_valid,
   input  logic                   out_ready,
   output cmap_pkg::seg_beat_type out_beat
);
   import cmap_pkg::*;

   localparam logic [CW-1:0] K1  = CW'(ONE_L);
   localparam logic [CW-1:0] K3  = CW'(ONE_L * 3);
   localparam logic [CW-1:0] K5  = CW'(ONE_L * 5);
   localparam logic [CW-1:0] K7  = CW'(ONE_L * 7);
   localparam logic [CW-1:0] K14 = CW'(ONE_L * 14);
   localparam logic [CW-1:0] K17 = CW'(ONE_L * 17);
   localparam logic [CW-1:0] K19 = CW'(ONE_L * 19);

   logic          valid_ff;
   logic          valid_in;
   seg_beat_type  beat_ff;
   seg_beat_type  beat_in;
   logic [CW-1:0] x10;
   logic [CW-1:0] x20;
   logic [CW-1:0] diff;

   // Compare 10x and 20x against the breakpoints; a hit goes to the higher segment
   always_comb begin
      x10 = CW'(in_beat.x) * CW'(10);
      x20 = CW'(in_beat.x) * CW'(20);
      if (x10 < K1) begin
         beat_in.seg = SEG_DARK;
         diff        = CW'(in_beat.x);
      end else if (x10 < K3) begin
         beat_in.seg = SEG_BLUE;
         diff        = x10 - K1;
      end else if (x10 < K5) begin
         beat_in.seg = SEG_CYAN;
         diff        = x10 - K3;
      end else if (x10 < K7) begin
         beat_in.seg = SEG_GREEN;
         diff        = x10 - K5;
      end else if (x20 < K17) begin
         beat_in.seg = SEG_YELLOW;
         diff        = x20 - K14;
      end else if (x20 < K19) begin
         beat_in.seg = SEG_ORANGE;
         diff        = x20 - K17;
      end else begin
         beat_in.seg = SEG_HOT;
         diff        = x20 - K19;
      end
      beat_in.u = diff[UW-1:0];
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         beat_ff <= beat_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_beat  = beat_ff;

endmodule

FILE: sv/cmap_ramp.sv
// Third pipeline stage of the colormap: multiplies the ramp offset by each
// channel's slope constant. Depends on cmap_pkg.
`timescale 1ns / 1ps

module cmap_ramp (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  cmap_pkg::seg_beat_type  in_beat,
   output logic                    out_valid,
   input  logic                    out_ready,
   output cmap_pkg::prod_beat_type out_beat
);
   import cmap_pkg::*;

   localparam int FW = UW + MULT_W;

   logic          valid_ff;
   logic          valid_in;
   prod_beat_type beat_ff;
   prod_beat_type beat_in;
   coef_type      c_red;
   coef_type      c_green;
   coef_type      c_blue;
   logic [FW-1:0] full_red;
   logic [FW-1:0] full_green;
   logic [FW-1:0] full_blue;

   // Slope times offset; every product stays below 512*ONE
   always_comb begin
      c_red      = coef_red(in_beat.seg);
      c_green    = coef_green(in_beat.seg);
      c_blue     = coef_blue(in_beat.seg);
      full_red   = FW'(in_beat.u) * FW'(c_red.mult);
      full_green = FW'(in_beat.u) * FW'(c_green.mult);
      full_blue  = FW'(in_beat.u) * FW'(c_blue.mult);
      beat_in.seg     = in_beat.seg;
      beat_in.p_red   = full_red[PW-1:0];
      beat_in.p_green = full_green[PW-1:0];
      beat_in.p_blue  = full_blue[PW-1:0];
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         beat_ff <= beat_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_beat  = beat_ff;

endmodule

FILE: sv/cmap_scale.sv
// Last pipeline stage of the colormap: scales each product down by its divisor,
// adds or subtracts it from the base colour and holds the result beat.
// Depends on cmap_pkg.
`timescale 1ns / 1ps

module cmap_scale (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  cmap_pkg::prod_beat_type in_beat,
   output logic                    out_valid,
   input  logic                    out_ready,
   output cmap_pkg::rgb_beat_type  out_beat
);
   import cmap_pkg::*;

   // Divide by ONE or 2*ONE by shifting; by 3*ONE shift first, then divide the
   // small quotient by three with a reciprocal (exact below 512)
   function automatic logic [CH_W-1:0] scale_chan(input logic [PW-1:0] p,
                                                  input coef_type c);
      logic [9:0]  c1;
      logic [9:0]  c2;
      logic [9:0]  t3;
      logic [17:0] prod3;
      logic [8:0]  q;
      logic [8:0]  res;
      c1 = {1'b0, p[PW-1:FRAC_BITS]} + {9'd0, c.neg & (|p[FRAC_BITS-1:0])};
      c2 = {2'b0, p[PW-1:FRAC_BITS+1]} + {9'd0, c.neg & (|p[FRAC_BITS:0])};
      t3 = c.neg ? c1 + 10'd2 : c1;
      prod3 = {8'd0, t3} * 18'd171;
      case (c.div)
         DIV_ONE:   q = c1[8:0];
         DIV_TWO:   q = c2[8:0];
         DIV_THREE: q = prod3[17:9];
         default:   q = '0;
      endcase
      res = c.neg ? {1'b0, c.base} - q : {1'b0, c.base} + q;
      return res[CH_W-1:0];
   endfunction

   logic         valid_ff;
   logic         valid_in;
   rgb_beat_type beat_ff;
   rgb_beat_type beat_in;

   always_comb begin
      beat_in.red   = scale_chan(in_beat.p_red,   coef_red(in_beat.seg));
      beat_in.green = scale_chan(in_beat.p_green, coef_green(in_beat.seg));
      beat_in.blue  = scale_chan(in_beat.p_blue,  coef_blue(in_beat.seg));
   end

   // Hold the result until the consumer takes it
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         beat_ff <= beat_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_beat  = beat_ff;

endmodule

FILE: sv/intensity_to_rgb_colormap.sv
// Top level of the intensity-to-RGB waterfall colormap.
// Depends on cmap_pkg, cmap_clamp, cmap_segment, cmap_ramp and cmap_scale.
`timescale 1ns / 1ps

// The block takes one signed Q16 intensity per beat and returns one RGB colour
// per beat, one item every cycle while rsp_ready is high. The four register stages
// between an accepted intensity and its result on rsp_ are:
// clamp to 0..1, segment search with offset, constant slope multiply, then
// divide and base add into the output register. Each stage holds its beat
// while the next stage is full, so a stall on rsp_ready backs up through the
// pipeline without dropping or repeating a beat, and req_ready stays high
// whenever rsp_ready is high. Breakpoints are exact: a value right on one
// falls into the higher segment.
module intensity_to_rgb_colormap (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [cmap_pkg::IN_W-1:0] req_intensity,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [cmap_pkg::CH_W-1:0]        rsp_red,
   output logic [cmap_pkg::CH_W-1:0]        rsp_green,
   output logic [cmap_pkg::CH_W-1:0]        rsp_blue
);
   import cmap_pkg::*;

   logic          s1_valid;
   logic          s1_ready;
   x_beat_type    s1_beat;
   logic          s2_valid;
   logic          s2_ready;
   seg_beat_type  s2_beat;
   logic          s3_valid;
   logic          s3_ready;
   prod_beat_type s3_beat;
   rgb_beat_type  s4_beat;

   cmap_clamp u_clamp (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_valid),
      .in_ready     (req_ready),
      .in_intensity (req_intensity),
      .out_valid    (s1_valid),
      .out_ready    (s1_ready),
      .out_beat     (s1_beat)
   );

   cmap_segment u_segment (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_beat   (s1_beat),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_beat  (s2_beat)
   );

   cmap_ramp u_ramp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_ready  (s2_ready),
      .in_beat   (s2_beat),
      .out_valid (s3_valid),
      .out_ready (s3_ready),
      .out_beat  (s3_beat)
   );

   cmap_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid),
      .in_ready  (s3_ready),
      .in_beat   (s3_beat),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_beat  (s4_beat)
   );

   assign rsp_red   = s4_beat.red;
   assign rsp_green = s4_beat.green;
   assign rsp_blue  = s4_beat.blue;

endmodule

FILE: sv/cmap_checker.sv
// Port-level checker for the colormap, bound to the top level.
// Depends on the top level's port list only.
`timescale 1ns / 1ps

module cmap_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic signed [17:0] req_intensity,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [7:0]         rsp_red,
   input logic [7:0]         rsp_green,
   input logic [7:0]         rsp_blue
);

   logic [2:0] occ_ff;
   logic [2:0] occ_in;

   // Count beats in flight between the two channels
   always_comb begin
      occ_in = occ_ff;
      if (req_valid && req_ready && !(rsp_valid && rsp_ready)) begin
         occ_in = occ_ff + 3'd1;
      end else if (!(req_valid && req_ready) && rsp_valid && rsp_ready) begin
         occ_in = occ_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 3'd0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_red)
         && $stable(rsp_green) && $stable(rsp_blue))
      else $error("result beat changed while stalled");

   a_no_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("request stalled while result side is ready");

   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid |-> occ_ff != 3'd0) && occ_ff <= 3'd4)
      else $error("result without request or pipeline overfilled");

   a_negative_black: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_intensity[17]) ##1 rsp_ready ##1 rsp_ready
         ##1 rsp_ready |=> rsp_valid && rsp_red == 8'd0 && rsp_green == 8'd0
         && rsp_blue == 8'd0)
      else $error("negative intensity did not map to black");

   a_full_red: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_red == 8'd255 |-> rsp_green == 8'd0 || rsp_blue == 8'd0)
      else $error("saturated red with both green and blue lit");

endmodule

bind intensity_to_rgb_colormap cmap_checker u_cmap_checker (.*);

FILE: tb/tb_top.sv
// Self-checking testbench for the intensity-to-RGB colormap: random and edge intensities
// go in on req_, and every rsp_ colour is checked against an in-bench prediction.
// Depends on cmap_pkg and intensity_to_rgb_colormap.
`timescale 1ns / 1ps

module tb_top;
   import cmap_pkg::*;

   // Hold the predicted colours in acceptance order and compare them with the beats
   // that come out
   class colour_scoreboard;
      rgb_beat_type pending_colours[$];
      int unsigned  error_count;

      function new();
         error_count = 0;
      endfunction

      // Map one sample to its colour: clamp to 0..1, then use a linear ramp per segment
      function rgb_beat_type predict_colour(logic signed [IN_W-1:0] sample);
         longint unsigned one, x, x10, x20, u, r, g, b;
         rgb_beat_type c;
         one = ONE_L;
         if (sample[IN_W-1]) begin
            x = 0;
         end else begin
            x = {{(64-IN_W){1'b0}}, sample};
            if (x > one) x = one;
         end
         x10 = 10 * x;
         x20 = 20 * x;
         if (x10 < one) begin
            r = 0;
            g = (200 * x) / one;
            b = (300 * x) / one;
         end else if (x10 < 3 * one) begin
            u = x10 - one;
            r = 0;
            g = 20 + (30 * u) / one;
            b = 30 + (75 * u) / one;
         end else if (x10 < 5 * one) begin
            u = x10 - 3 * one;
            r = (40 * u) / one;
            g = 80 + (40 * u) / one;
            b = 180 + (75 * u) / (2 * one);
         end else if (x10 < 7 * one) begin
            u = x10 - 5 * one;
            r = 80 + (40 * u) / one;
            g = 160 + (95 * u) / (2 * one);
            b = 255 - (100 * u + one - 1) / one;
         end else if (x20 < 17 * one) begin
            u = x20 - 14 * one;
            r = 160 + (95 * u) / (3 * one);
            g = 255;
            b = 55 - (55 * u + 3 * one - 1) / (3 * one);
         end else if (x20 < 19 * one) begin
            u = x20 - 17 * one;
            r = 255;
            g = 255 - (64 * u + one - 1) / one;
            b = 0;
         end else begin
            u = x20 - 19 * one;
            r = 255;
            g = 0;
            b = (100 * u) / one;
         end
         c.red   = r[CH_W-1:0];
         c.green = g[CH_W-1:0];
         c.blue  = b[CH_W-1:0];
         return c;
      endfunction

      function void note_intensity(logic signed [IN_W-1:0] sample);
         pending_colours.push_back(predict_colour(sample));
      endfunction

      function void check_colour(logic [CH_W-1:0] red, logic [CH_W-1:0] green,
                                 logic [CH_W-1:0] blue);
         rgb_beat_type want;
         if (pending_colours.size() == 0) begin
            $error("rsp beat with no colour pending: red %0d green %0d blue %0d",
                   red, green, blue);
            error_count++;
            return;
         end
         want = pending_colours.pop_front();
         if (red !== want.red) begin
            $error("red mismatch: expected %0d, actual %0d", want.red, red);
            error_count++;
         end
         if (green !== want.green) begin
            $error("green mismatch: expected %0d, actual %0d", want.green, green);
            error_count++;
         end
         if (blue !== want.blue) begin
            $error("blue mismatch: expected %0d, actual %0d", want.blue, blue);
            error_count++;
         end
      endfunction

      function int unsigned outstanding();
         return pending_colours.size();
      endfunction
   endclass

   localparam int RANDOM_BEATS = 500;
   localparam int HOLD_CYCLES  = 80;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic signed [IN_W-1:0]   req_intensity;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic [CH_W-1:0]          rsp_red;
   logic [CH_W-1:0]          rsp_green;
   logic [CH_W-1:0]          rsp_blue;

   colour_scoreboard board;
   bit                       steady;       // neither side idles while set
   bit                       hold_output;  // ask the receiver for a long hold-off

   intensity_to_rgb_colormap uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_intensity (req_intensity),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_red       (rsp_red),
      .rsp_green     (rsp_green),
      .rsp_blue      (rsp_blue)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Lowest intensity that lands in the segment above breakpoint k
   function automatic longint unsigned breakpoint_of(int k);
      longint unsigned num[6] = '{1, 3, 5, 7, 17, 19};
      longint unsigned den[6] = '{10, 10, 10, 10, 20, 20};
      return (num[k] * ONE_L + den[k] - 1) / den[k];
   endfunction

   // Draw one random sample, weighted towards the 0..1 range and the breakpoints
   function automatic logic signed [IN_W-1:0] pick_intensity();
      int unsigned roll;
      longint      v;
      roll = $urandom_range(99);
      if (roll < 50)
         v = $urandom_range(32'(ONE_L));
      else if (roll < 65)
         v = longint'(breakpoint_of($urandom_range(5))) + $urandom_range(4) - 2;
      else if (roll < 80)
         v = $urandom();
      else if (roll < 90)
         v = -longint'($urandom_range(1, 1 << (IN_W - 1)));
      else
         v = $urandom_range(32'(ONE_L), (1 << (IN_W - 1)) - 1);
      return v[IN_W-1:0];
   endfunction

   // Offer one beat, after a random gap unless told not to, and hold it until accepted
   task automatic send_intensity(input logic signed [IN_W-1:0] sample, input bit no_gaps);
      int unsigned gap;
      gap = 0;
      if (!no_gaps)
         while ($urandom_range(99) < 35) gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_intensity <= sample;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Drop valid and wait until every predicted colour has come back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (board.outstanding() != 0) @(negedge clock);
   endtask

   // Note accepted inputs and check accepted results at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) board.note_intensity(req_intensity);
         if (rsp_valid && rsp_ready) board.check_colour(rsp_red, rsp_green, rsp_blue);
      end
   end

   // Receiver: random back-pressure, with a long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_output) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_output = 1'b0;
         end
         rsp_ready <= steady || ($urandom_range(99) >= 35);
      end
   end

   // Main stimulus
   initial begin
      longint unsigned bp;
      board         = new();
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_intensity = '0;
      steady        = 1'b0;
      hold_output   = 1'b0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: range ends, both sides of every breakpoint, and the clamp above one
      send_intensity({1'b1, {(IN_W-1){1'b0}}}, 1'b0);
      send_intensity('1, 1'b0);
      send_intensity('0, 1'b0);
      send_intensity(IN_W'(1), 1'b0);
      for (int k = 0; k < 6; k++) begin
         bp = breakpoint_of(k);
         send_intensity(IN_W'(bp - 1), 1'b0);
         send_intensity(IN_W'(bp), 1'b0);
      end
      send_intensity(IN_W'(ONE_L - 1), 1'b0);
      send_intensity(IN_W'(ONE_L), 1'b0);
      send_intensity(IN_W'(ONE_L + 1), 1'b0);
      send_intensity({1'b0, {(IN_W-1){1'b1}}}, 1'b0);
      wait_for_drain();

      // Random: one long hold-off at the output, one full drain, one stretch at full rate
      for (int i = 0; i < RANDOM_BEATS; i++) begin
         if (i == 150) hold_output = 1'b1;
         if (i == 250) wait_for_drain();
         steady = (i >= 300 && i < 400);
         send_intensity(pick_intensity(), (i >= 150 && i < 190) || steady);
      end
      steady = 1'b0;

      wait_for_drain();
      repeat (8) @(negedge clock);
      if (board.error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Give up on a hung run
   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

FILE: intensity_to_rgb_colormap.f
sv/cmap_pkg.sv
sv/cmap_clamp.sv
sv/cmap_segment.sv
sv/cmap_ramp.sv
sv/cmap_scale.sv
sv/intensity_to_rgb_colormap.sv
sv/cmap_checker.sv
tb/tb_top.sv
